FILE: rtl/bounded_integer_set_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded integer set.
// Each macro samples on the rising edge of clk and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_ASSERT_SVH
`define BOUNDED_INTEGER_SET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_integer_set: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_integer_set: next-cycle check failed");

`endif

FILE: rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants, types and codes of the bounded integer set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 7;
  localparam int CMD_W    = 2;

  typedef logic [DATA_W-1:0]        data_t;
  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [COUNT_W-1:0]       count_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  // One finished result on its way to the output register.
  typedef struct packed {
    logic   found;
    logic   accepted;
    count_t count;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/bis_in_if.sv
// ----------------------------------------------------------------------------
// bis_in_if
// Input channel: a command and a value under a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bis_in_if import bis_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  value_t             value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/bis_out_if.sv
// ----------------------------------------------------------------------------
// bis_out_if
// Result channel: found, accepted and count under a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bis_out_if import bis_pkg::*;;
  logic   valid;
  logic   ready;
  logic   found;
  logic   accepted;
  count_t count;

  modport source (output valid, output found, output accepted, output count, input ready);
  modport sink   (input valid, input found, input accepted, input count, output ready);
endinterface

`default_nettype wire

FILE: rtl/bounded_integer_set.sv
// ----------------------------------------------------------------------------
// bounded_integer_set
// Fixed-capacity unordered list of 32-bit integers with swap-remove.
// ----------------------------------------------------------------------------
// The list lives in one RAM with a single read port, so membership and
// remove scan the live entries one per cycle. Items are processed one at a
// time. Clear and add put their result into the output register from the
// execute state. Query and remove scan from index 0 up to the first match
// or the last live entry, then finish; remove on a match first reads the last
// entry and writes it into the freed slot. An empty list answers query and
// remove without a scan. A finished result waits in place while the output
// register still holds an earlier one. The next item is accepted while the
// previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module bounded_integer_set import bis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bis_in_if.sink    in_chan,
  bis_out_if.source out_chan
);

  logic  emit;
  res_t  res;
  logic  out_free;
  logic  wr_en;
  idx_t  wr_addr;
  data_t wr_data;
  idx_t  rd_addr;
  data_t rd_data;

  bis_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_free (out_free),
    .emit     (emit),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  bis_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .emit     (emit),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

FILE: rtl/bis_ram.sv
// ----------------------------------------------------------------------------
// bis_ram
// Generic simple dual-port RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/bis_ctrl.sv
// ----------------------------------------------------------------------------
// bis_ctrl
// Command sequencer: appends, scans the live entries one per cycle through
// the RAM read port, and performs the swap on remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_integer_set_assert.svh"

module bis_ctrl import bis_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bis_in_if.sink     in_chan,
  input  wire logic  out_free,
  output logic       emit,
  output res_t       res,
  output logic       wr_en,
  output idx_t       wr_addr,
  output data_t      wr_data,
  output idx_t       rd_addr,
  input  wire data_t rd_data
);

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  value_t val_r, val_nxt;
  cnt_t   cnt_r, cnt_nxt;
  idx_t   rd_addr_r, rd_addr_nxt;
  idx_t   pos_r, pos_nxt;
  logic   found_r, found_nxt;
  logic   match;
  logic   at_last;
  idx_t   last_addr;

  assign match     = (rd_data == $unsigned(val_r));
  assign at_last   = ((CNT_W'(rd_addr_r) + CNT_W'(1)) == cnt_r);
  assign last_addr = IDX_W'(cnt_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    rd_addr_r <= rd_addr_nxt;
    pos_r     <= pos_nxt;
    found_r   <= found_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rd_addr_nxt   = rd_addr_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    in_chan.ready = 1'b0;
    emit          = 1'b0;
    res           = '{found: found_r, accepted: 1'b0, count: COUNT_W'(cnt_r)};
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = rd_data;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          cmd_nxt   = cmd_t'(in_chan.command);
          val_nxt   = in_chan.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_r)
          CMD_CLEAR: begin
            if (out_free) begin
              cnt_nxt   = '0;
              emit      = 1'b1;
              res       = '{found: 1'b0, accepted: 1'b0, count: '0};
              state_nxt = S_IDLE;
            end
          end
          CMD_ADD: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (cnt_r < CNT_W'(CAPACITY)) begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(cnt_r);
                wr_data = $unsigned(val_r);
                cnt_nxt = cnt_r + CNT_W'(1);
                res     = '{found: 1'b0, accepted: 1'b1,
                            count: COUNT_W'(cnt_r + CNT_W'(1))};
              end else begin
                res     = '{found: 1'b0, accepted: 1'b0, count: COUNT_W'(cnt_r)};
              end
            end
          end
          CMD_REMOVE, CMD_QUERY: begin
            found_nxt = 1'b0;
            if (cnt_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              rd_addr     = '0;
              rd_addr_nxt = '0;
              state_nxt   = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // The data of entry rd_addr_r arrives in this cycle.
      S_SCAN: begin
        if (match) begin
          found_nxt = 1'b1;
          pos_nxt   = rd_addr_r;
          if (cmd_r == CMD_REMOVE) begin
            rd_addr   = last_addr;
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (at_last) begin
          state_nxt = S_DONE;
        end else begin
          rd_addr     = rd_addr_r + IDX_W'(1);
          rd_addr_nxt = rd_addr_r + IDX_W'(1);
        end
      end

      // The last live entry is read back; move it into the freed slot.
      S_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = rd_data;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `BIS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `BIS_ASSERT_SAME(a_write_source, wr_en, (state_r == S_EXEC && cmd_r == CMD_ADD) || state_r == S_LAST)
  `BIS_ASSERT_SAME(a_scan_live, state_r == S_SCAN, CNT_W'(rd_addr_r) < cnt_r)
  `BIS_ASSERT_NEXT(a_swap_shrinks, state_r == S_LAST, cnt_r == CNT_W'($past(cnt_r) - CNT_W'(1)))

endmodule

`default_nettype wire

FILE: rtl/bis_out_stage.sv
// ----------------------------------------------------------------------------
// bis_out_stage
// Output register of the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_out_stage import bis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic emit,
  input  wire res_t res,
  output logic      out_free,
  bis_out_if.source out_chan
);

  logic valid_r, valid_nxt;
  res_t res_r, res_nxt;

  // The register can take a new result when empty or emptying now.
  assign out_free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (emit) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_chan.valid    = valid_r;
  assign out_chan.found    = res_r.found;
  assign out_chan.accepted = res_r.accepted;
  assign out_chan.count    = res_r.count;

endmodule

`default_nettype wire
